// ===== sv/ptt_pkg.sv =====
// Package for the periodic timer table: command and status codes, sequencer
// states, compare-unit result struct and default sizes. No dependencies.
package ptt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int KEY_BYTES_DEF   = 8;

    localparam int S_DATA_W = 136;  // cmd, task_key, interval_ms, now_ms, padded
    localparam int M_DATA_W = 80;   // status, out_key, slot, entry_count, padded

    typedef enum logic [1:0] {
        CMD_REGISTER   = 2'd0,
        CMD_UNREGISTER = 2'd1,
        CMD_TICK       = 2'd2,
        CMD_QUERY      = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        STAT_REGISTERED = 4'd0,
        STAT_DUPLICATE  = 4'd1,
        STAT_FULL       = 4'd2,
        STAT_REMOVED    = 4'd3,
        STAT_NOT_FOUND  = 4'd4,
        STAT_FIRED      = 4'd5,
        STAT_NONE_DUE   = 4'd6,
        STAT_PRESENT    = 4'd7,
        STAT_ABSENT     = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        SEQ_IDLE  = 2'd0,
        SEQ_SCAN  = 2'd1,
        SEQ_SHIFT = 2'd2
    } seq_state_t;

    typedef struct packed {
        logic key_hit;
        logic due;
    } cmp_res_t;

endpackage

// ===== sv/ptt_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module ptt_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/ptt_cmp.sv =====
// Shared compare unit: key match and wrapping due test for one table entry.
// Depends on ptt_pkg.
module ptt_cmp #(
    parameter int KEY_W = 64
) (
    input  logic [KEY_W-1:0]  entry_key,
    input  logic [KEY_W-1:0]  probe_key,
    input  logic [31:0]       now_ms,
    input  logic [31:0]       period,
    input  logic [31:0]       last_fire,
    output ptt_pkg::cmp_res_t res
);

    logic [31:0] elapsed;

    assign elapsed     = now_ms - last_fire;
    assign res.key_hit = (entry_key == probe_key);
    assign res.due     = (elapsed >= period);

endmodule

// ===== sv/periodic_timer_table.sv =====
// Periodic timer table top level: command capture, scan sequencer, output
// register. Depends on ptt_pkg, ptt_ram, ptt_cmp.
//
// One command is taken at a time. Every command walks the table from slot 0
// through one RAM read per cycle while the scan is not held; unregister then
// moves each later entry down one slot, one per cycle, and a tick holds the
// scan while a fired transaction waits on m_tready. A fired result is held
// back until the next due entry or the end of the scan, so that the final
// result of a command always carries tlast. No clearing pass after reset.
module periodic_timer_table #(
    parameter int TABLE_DEPTH = ptt_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BYTES   = ptt_pkg::KEY_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cmd[1:0], task_key[65:2], interval_ms[97:66], now_ms[129:98], zero pad
    input  logic [ptt_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[3:0], out_key[67:4], slot[71:68], entry_count[76:72], zero pad
    output logic [ptt_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tlast
);

    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W = KEY_BYTES * 8;
    localparam int ENT_W = KEY_W + 64;

    ptt_pkg::seq_state_t state_reg, state_next;
    ptt_pkg::cmd_t       cmd_reg, cmd_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [31:0]         interval_reg, interval_next;
    logic [31:0]         now_reg, now_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [3:0]          pos_reg, pos_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [KEY_W-1:0]    pend_key_reg, pend_key_next;
    logic [3:0]          pend_slot_reg, pend_slot_next;

    logic                m_valid_reg, m_valid_next;
    ptt_pkg::status_t    m_status_reg, m_status_next;
    logic [KEY_W-1:0]    m_key_reg, m_key_next;
    logic [3:0]          m_slot_reg, m_slot_next;
    logic [4:0]          m_count_reg, m_count_next;
    logic                m_last_reg, m_last_next;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [ENT_W-1:0]    wr_data;
    logic [ENT_W-1:0]    rd_data;
    logic [KEY_W-1:0]    rd_key;
    logic [31:0]         rd_period;
    logic [31:0]         rd_last_fire;
    ptt_pkg::cmp_res_t   cmp_res;

    logic                out_free;
    logic                at_end;
    logic                finish;
    logic                to_shift;
    logic [CW-1:0]       count_inc;
    logic [CW-1:0]       count_dec;
    logic [CW+3:0]       idx_ext;
    logic [CW+3:0]       count_slot_ext;
    logic [CW+4:0]       count_ext;
    logic [CW+4:0]       count_inc_ext;
    logic [CW+4:0]       count_dec_ext;
    logic [63:0]         out_key_w;

    assign rd_key       = rd_data[KEY_W-1:0];
    assign rd_period    = rd_data[KEY_W +: 32];
    assign rd_last_fire = rd_data[KEY_W+32 +: 32];

    ptt_ram #(
        .WIDTH(ENT_W),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(idx_next[AW-1:0]),
        .rd_data(rd_data)
    );

    ptt_cmp #(
        .KEY_W(KEY_W)
    ) u_cmp (
        .entry_key(rd_key),
        .probe_key(key_reg),
        .now_ms   (now_reg),
        .period   (rd_period),
        .last_fire(rd_last_fire),
        .res      (cmp_res)
    );

    assign s_tready       = (state_reg == ptt_pkg::SEQ_IDLE);
    assign out_free       = !m_valid_reg || m_tready;
    assign at_end         = (idx_reg == count_reg);
    assign count_inc      = count_reg + CW'(1);
    assign count_dec      = count_reg - CW'(1);
    assign idx_ext        = {4'b0, idx_reg};
    assign count_slot_ext = {4'b0, count_reg};
    assign count_ext      = {5'b0, count_reg};
    assign count_inc_ext  = {5'b0, count_inc};
    assign count_dec_ext  = {5'b0, count_dec};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ptt_pkg::SEQ_IDLE: begin
                if (s_tvalid) begin
                    state_next = ptt_pkg::SEQ_SCAN;
                end
            end
            ptt_pkg::SEQ_SCAN: begin
                if (finish) begin
                    state_next = ptt_pkg::SEQ_IDLE;
                end else if (to_shift) begin
                    state_next = ptt_pkg::SEQ_SHIFT;
                end
            end
            ptt_pkg::SEQ_SHIFT: begin
                if (finish) begin
                    state_next = ptt_pkg::SEQ_IDLE;
                end
            end
            default: state_next = ptt_pkg::SEQ_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        interval_next   = interval_reg;
        now_next        = now_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        pend_valid_next = pend_valid_reg;
        pend_key_next   = pend_key_reg;
        pend_slot_next  = pend_slot_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_key_next      = m_key_reg;
        m_slot_next     = m_slot_reg;
        m_count_next    = m_count_reg;
        m_last_next     = m_last_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg[AW-1:0];
        wr_data         = rd_data;
        finish          = 1'b0;
        to_shift        = 1'b0;

        case (state_reg)
            ptt_pkg::SEQ_IDLE: begin
                if (s_tvalid) begin
                    cmd_next        = ptt_pkg::cmd_t'(s_tdata[1:0]);
                    key_next        = s_tdata[2 +: KEY_W];
                    interval_next   = s_tdata[97:66];
                    now_next        = s_tdata[129:98];
                    idx_next        = '0;
                    pend_valid_next = 1'b0;
                end
            end

            ptt_pkg::SEQ_SCAN: begin
                case (cmd_reg)
                    ptt_pkg::CMD_TICK: begin
                        if (at_end) begin
                            if (out_free) begin
                                m_valid_next    = 1'b1;
                                m_last_next     = 1'b1;
                                m_count_next    = count_ext[4:0];
                                pend_valid_next = 1'b0;
                                finish          = 1'b1;
                                if (pend_valid_reg) begin
                                    m_status_next = ptt_pkg::STAT_FIRED;
                                    m_key_next    = pend_key_reg;
                                    m_slot_next   = pend_slot_reg;
                                end else begin
                                    m_status_next = ptt_pkg::STAT_NONE_DUE;
                                    m_key_next    = '0;
                                    m_slot_next   = '0;
                                end
                            end
                        end else if (cmp_res.due) begin
                            if (!pend_valid_reg || out_free) begin
                                if (pend_valid_reg) begin
                                    m_valid_next  = 1'b1;
                                    m_last_next   = 1'b0;
                                    m_status_next = ptt_pkg::STAT_FIRED;
                                    m_key_next    = pend_key_reg;
                                    m_slot_next   = pend_slot_reg;
                                    m_count_next  = count_ext[4:0];
                                end
                                pend_valid_next = 1'b1;
                                pend_key_next   = rd_key;
                                pend_slot_next  = idx_ext[3:0];
                                wr_en           = 1'b1;
                                wr_data         = {now_reg, rd_period, rd_key};
                                idx_next        = idx_reg + CW'(1);
                            end
                        end else begin
                            idx_next = idx_reg + CW'(1);
                        end
                    end

                    ptt_pkg::CMD_REGISTER: begin
                        if (at_end) begin
                            if (out_free) begin
                                m_valid_next = 1'b1;
                                m_last_next  = 1'b1;
                                m_key_next   = key_reg;
                                finish       = 1'b1;
                                if (count_reg == CW'(TABLE_DEPTH)) begin
                                    m_status_next = ptt_pkg::STAT_FULL;
                                    m_slot_next   = '0;
                                    m_count_next  = count_ext[4:0];
                                end else begin
                                    wr_en         = 1'b1;
                                    wr_addr       = count_reg[AW-1:0];
                                    wr_data       = {now_reg, interval_reg, key_reg};
                                    count_next    = count_inc;
                                    m_status_next = ptt_pkg::STAT_REGISTERED;
                                    m_slot_next   = count_slot_ext[3:0];
                                    m_count_next  = count_inc_ext[4:0];
                                end
                            end
                        end else if (cmp_res.key_hit) begin
                            if (out_free) begin
                                m_valid_next  = 1'b1;
                                m_last_next   = 1'b1;
                                m_key_next    = key_reg;
                                m_status_next = ptt_pkg::STAT_DUPLICATE;
                                m_slot_next   = idx_ext[3:0];
                                m_count_next  = count_ext[4:0];
                                finish        = 1'b1;
                            end
                        end else begin
                            idx_next = idx_reg + CW'(1);
                        end
                    end

                    ptt_pkg::CMD_UNREGISTER: begin
                        if (at_end) begin
                            if (out_free) begin
                                m_valid_next  = 1'b1;
                                m_last_next   = 1'b1;
                                m_key_next    = key_reg;
                                m_status_next = ptt_pkg::STAT_NOT_FOUND;
                                m_slot_next   = '0;
                                m_count_next  = count_ext[4:0];
                                finish        = 1'b1;
                            end
                        end else if (cmp_res.key_hit) begin
                            pos_next = idx_ext[3:0];
                            idx_next = idx_reg + CW'(1);
                            to_shift = 1'b1;
                        end else begin
                            idx_next = idx_reg + CW'(1);
                        end
                    end

                    ptt_pkg::CMD_QUERY: begin
                        if (at_end || cmp_res.key_hit) begin
                            if (out_free) begin
                                m_valid_next = 1'b1;
                                m_last_next  = 1'b1;
                                m_key_next   = key_reg;
                                m_count_next = count_ext[4:0];
                                finish       = 1'b1;
                                if (at_end) begin
                                    m_status_next = ptt_pkg::STAT_ABSENT;
                                    m_slot_next   = '0;
                                end else begin
                                    m_status_next = ptt_pkg::STAT_PRESENT;
                                    m_slot_next   = idx_ext[3:0];
                                end
                            end
                        end else begin
                            idx_next = idx_reg + CW'(1);
                        end
                    end

                    default: finish = 1'b1;
                endcase
            end

            ptt_pkg::SEQ_SHIFT: begin
                if (at_end) begin
                    if (out_free) begin
                        count_next    = count_dec;
                        m_valid_next  = 1'b1;
                        m_last_next   = 1'b1;
                        m_key_next    = key_reg;
                        m_status_next = ptt_pkg::STAT_REMOVED;
                        m_slot_next   = pos_reg;
                        m_count_next  = count_dec_ext[4:0];
                        finish        = 1'b1;
                    end
                end else begin
                    // move entry idx down one slot
                    wr_en    = 1'b1;
                    wr_addr  = idx_reg[AW-1:0] - AW'(1);
                    wr_data  = rd_data;
                    idx_next = idx_reg + CW'(1);
                end
            end

            default: finish = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ptt_pkg::SEQ_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        interval_reg  <= interval_next;
        now_reg       <= now_next;
        pos_reg       <= pos_next;
        pend_key_reg  <= pend_key_next;
        pend_slot_reg <= pend_slot_next;
        m_status_reg  <= m_status_next;
        m_key_reg     <= m_key_next;
        m_slot_reg    <= m_slot_next;
        m_count_reg   <= m_count_next;
        m_last_reg    <= m_last_next;
    end

    always_comb begin
        out_key_w              = '0;
        out_key_w[KEY_W-1:0]   = m_key_reg;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {3'b0, m_count_reg, m_slot_reg, out_key_w, m_status_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("timer count above table depth");

    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pend_valid_reg)
        else $error("held fired result left behind at end of tick");

    a_none_due_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == ptt_pkg::STAT_NONE_DUE) |-> m_last_reg)
        else $error("none-due result without tlast");

    a_shift_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ptt_pkg::SEQ_SHIFT) |-> (cmd_reg == ptt_pkg::CMD_UNREGISTER))
        else $error("table shift outside unregister");

endmodule
